FILE: rtl/core/ear_pkg.sv
// Shared types, constants and tables for the event address rate limiter.
`default_nettype none

package ear_pkg;

    // Table geometry
    localparam int SLOT_COUNT = 16;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int ADDR_W     = 32;
    localparam int HITS_W     = 64;

    // Powers of ten that fit in a 64-bit counter
    localparam int POW10_N = 20;
    localparam logic [HITS_W-1:0] POW10 [POW10_N] = '{
        64'd1,
        64'd10,
        64'd100,
        64'd1000,
        64'd10000,
        64'd100000,
        64'd1000000,
        64'd10000000,
        64'd100000000,
        64'd1000000000,
        64'd10000000000,
        64'd100000000000,
        64'd1000000000000,
        64'd10000000000000,
        64'd100000000000000,
        64'd1000000000000000,
        64'd10000000000000000,
        64'd100000000000000000,
        64'd1000000000000000000,
        64'd10000000000000000000
    };

    // Result status codes
    typedef enum logic [1:0] {
        OUT_KNOWN = 2'd0,
        OUT_NEW   = 2'd1,
        OUT_FULL  = 2'd2
    } t_outcome;

    // Slot memory control from the sequencer
    typedef struct packed {
        logic             wr_addr_en;
        logic             wr_hits_en;
        logic [IDX_W-1:0] wr_idx;
        logic [IDX_W-1:0] rd_idx;
    } t_mem_ctl;

endpackage

`default_nettype wire

FILE: rtl/core/ear_slot_mem.sv
// Slot table storage: address and hit counter memories with registered read.
`default_nettype none

module ear_slot_mem
    import ear_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_mem_ctl          i_ctl,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [HITS_W-1:0] i_wr_hits,
    output logic      [ADDR_W-1:0] o_rd_addr,
    output logic      [HITS_W-1:0] o_rd_hits
);

    logic [ADDR_W-1:0] r_mem_addr [SLOT_COUNT];
    logic [HITS_W-1:0] r_mem_hits [SLOT_COUNT];

    // Write ports
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_addr_en) begin
            r_mem_addr[i_ctl.wr_idx] <= i_wr_addr;
        end
        if (i_ctl.wr_hits_en) begin
            r_mem_hits[i_ctl.wr_idx] <= i_wr_hits;
        end
    end

    // Registered read, both arrays at one index
    always_ff @(posedge i_clk) begin
        o_rd_addr <= r_mem_addr[i_ctl.rd_idx];
        o_rd_hits <= r_mem_hits[i_ctl.rd_idx];
    end

endmodule

`default_nettype wire

FILE: rtl/core/ear_pow10.sv
// Exact power-of-ten detector for a 64-bit hit count.
`default_nettype none

module ear_pow10
    import ear_pkg::*;
(
    input  wire logic [HITS_W-1:0] i_count,
    output logic                   o_is_pow10
);

    // Match against every table entry in parallel
    always_comb begin
        o_is_pow10 = 1'b0;
        for (int k = 0; k < POW10_N; k++) begin
            if (i_count == POW10[k]) begin
                o_is_pow10 = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/event_address_rate_limiter.sv
// Top level: per-address event counter with sequential slot search.
//
// Usage: drive i_event_address and pulse start while busy is low; the item is
// taken at that clock edge and busy rises on the next cycle. The block keeps a
// table of SLOT_COUNT addresses, each with a 64-bit saturating hit counter.
// The slots in use are searched one per cycle by a single 32-bit comparator
// fed from the registered read port of the slot memory.
// A hit at slot k is found after slots 0 to k are compared in turn, then its
// count is incremented and output; a new or dropped address is compared against
// every slot in use (none on an empty table), then claims a slot or is dropped.
// A result is on o_report, o_hit_total and o_outcome for exactly one cycle,
// marked by o_result_valid; the receiver cannot stall it. A new item may be
// started in the same cycle as the strobe.
// outcome: 0 known address, 1 new slot claimed, 2 table full (item dropped,
// hit total 0). report is set when the updated count is a power of ten.
// Reset (synchronous, active low) empties the table by clearing the slot
// count; the memories are not cleared and the contents of unused slots are never used.
`default_nettype none

module event_address_rate_limiter
    import ear_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [ADDR_W-1:0] i_event_address,
    output logic                   o_result_valid,
    output logic                   o_report,
    output logic      [HITS_W-1:0] o_hit_total,
    output logic      [1:0]        o_outcome
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_MISS   = 5'b00100,
        S_INC    = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [HITS_W-1:0] r_count, n_count;
    t_outcome          r_outcome, n_outcome;

    logic              r_res_valid;
    logic              r_report;
    logic [HITS_W-1:0] r_hit_total;
    t_outcome          r_res_outcome;

    t_mem_ctl          w_ctl;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [HITS_W-1:0] w_rd_hits;
    logic              w_match;
    logic              w_last;
    logic              w_accept;
    logic              w_is_pow10;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Shared comparator: stored address of the current slot against the item
    assign w_match = (w_rd_addr == r_addr);
    assign w_last  = ((r_idx + CNT_W'(1)) == r_used);

    ear_slot_mem u_mem (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_wr_addr (r_addr),
        .i_wr_hits (r_count),
        .o_rd_addr (w_rd_addr),
        .o_rd_hits (w_rd_hits)
    );

    ear_pow10 u_pow10 (
        .i_count    (r_count),
        .o_is_pow10 (w_is_pow10)
    );

    // Sequencer next state
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_idx     = r_idx;
        n_used    = r_used;
        n_count   = r_count;
        n_outcome = r_outcome;
        w_ctl.wr_addr_en = 1'b0;
        w_ctl.wr_hits_en = 1'b0;
        w_ctl.wr_idx     = r_idx[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_addr = i_event_address;
                    n_idx  = '0;
                    n_state = (r_used == '0) ? S_MISS : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_match) begin
                    n_outcome = OUT_KNOWN;
                    n_state   = S_INC;
                end else if (w_last) begin
                    n_state = S_MISS;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_MISS: begin
                if (r_used == CNT_W'(SLOT_COUNT)) begin
                    n_count   = '0;
                    n_outcome = OUT_FULL;
                end else begin
                    w_ctl.wr_addr_en = 1'b1;
                    w_ctl.wr_idx     = r_used[IDX_W-1:0];
                    n_idx     = r_used;
                    n_used    = r_used + CNT_W'(1);
                    n_count   = HITS_W'(1);
                    n_outcome = OUT_NEW;
                end
                n_state = S_OUT;
            end
            S_INC: begin
                // Saturating increment of the stored count
                n_count = (&w_rd_hits) ? w_rd_hits : w_rd_hits + HITS_W'(1);
                n_state = S_OUT;
            end
            S_OUT: begin
                w_ctl.wr_hits_en = (r_outcome != OUT_FULL);
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Read always runs one slot ahead of the compare
        w_ctl.rd_idx = n_idx[IDX_W-1:0];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_res_valid <= (r_state == S_OUT);
        end
    end

    // Working and result payload registers
    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_idx     <= n_idx;
        r_count   <= n_count;
        r_outcome <= n_outcome;
        if (r_state == S_OUT) begin
            r_report      <= w_is_pow10;
            r_hit_total   <= r_count;
            r_res_outcome <= r_outcome;
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_report       = r_report;
    assign o_hit_total    = r_hit_total;
    assign o_outcome      = r_res_outcome;

    // Checks
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held longer than one cycle");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(SLOT_COUNT))
        else $error("slot count above table size");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_outcome == OUT_FULL)) |-> (o_hit_total == '0 && !o_report))
        else $error("dropped item carries a count or report");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy did not rise after an accepted item");

    a_nonzero_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_outcome != OUT_FULL)) |-> (o_hit_total != '0))
        else $error("stored address produced a zero count");

endmodule

`default_nettype wire

FILE: dv/event_address_rate_limiter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the event address rate limiter: directed table, then random events.
module event_address_rate_limiter_tb;
    import ear_pkg::*;

    localparam int RESET_CYCLES    = 11;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int MAX_GAP         = 40;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int PHASE_N         = 4;
    localparam int DIRECTED_N      = 22;

    // One result item: what the block reports for a counted event
    typedef struct packed {
        logic             report;
        logic [HITS_W-1:0] hit_total;
        t_outcome         outcome;
    } tally_t;

    // Directed stimulus row; typed rows carry their expected tally
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              typed;
        tally_t            tally;
    } directed_row_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic [ADDR_W-1:0] i_event_address = '0;
    logic              busy;
    logic              o_result_valid;
    logic              o_report;
    logic [HITS_W-1:0] o_hit_total;
    logic [1:0]        o_outcome;

    event_address_rate_limiter u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_event_address(i_event_address),
        .o_result_valid (o_result_valid),
        .o_report       (o_report),
        .o_hit_total    (o_hit_total),
        .o_outcome      (o_outcome)
    );

    // Directed rows: empty table, extremes, fill to 16 slots, drops on a full table
    directed_row_t directed_rows [DIRECTED_N] = '{
        '{32'h0000_0000, 1'b1, '{1'b1, 64'd1, OUT_NEW}},
        '{32'h0000_0000, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b1, '{1'b1, 64'd1, OUT_NEW}},
        '{32'h0000_0001, 1'b0, '0},
        '{32'h8000_0000, 1'b0, '0},
        '{32'h5555_5555, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b0, '0},
        '{32'h0000_FFFF, 1'b0, '0},
        '{32'hFFFF_0000, 1'b0, '0},
        '{32'hFFFF_FFFE, 1'b0, '0},
        '{32'h0F0F_0F0F, 1'b0, '0},
        '{32'hF0F0_F0F0, 1'b0, '0},
        '{32'h0000_0002, 1'b0, '0},
        '{32'h4000_0000, 1'b0, '0},
        '{32'hDEAD_BEEF, 1'b0, '0},
        '{32'h0000_0100, 1'b0, '0},
        '{32'h00FF_00FF, 1'b0, '0},
        '{32'h1234_5678, 1'b1, '{1'b0, 64'd0, OUT_FULL}},
        '{32'hFFFF_FFFF, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b1, '{1'b0, 64'd0, OUT_FULL}},
        '{32'h00FF_00FF, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, '0}
    };

    // Sender idle percentage per random phase
    int phase_idle_pct [PHASE_N] = '{0, 51, 0, 19};

    // Shadow copy of the slot table
    logic [ADDR_W-1:0] shadow_addr [SLOT_COUNT];
    logic [HITS_W-1:0] shadow_hits [SLOT_COUNT];
    int                shadow_used = 0;

    tally_t expected_tallies [$];
    int     mismatch_count = 0;
    int     events_sent = 0;
    int     tallies_checked = 0;
    int     reports_seen = 0;
    int     drops_seen = 0;
    int     stall_cycles = 0;

    // Clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit is_decade(logic [HITS_W-1:0] n);
        logic [HITS_W-1:0] v;
        v = n;
        while (v >= HITS_W'(10) && v % HITS_W'(10) == '0)
            v = v / HITS_W'(10);
        return v == HITS_W'(1);
    endfunction

    // Count one event in the shadow table and return the tally it yields
    function automatic tally_t predict_tally(logic [ADDR_W-1:0] addr);
        tally_t t;
        int     idx;
        int     k;
        idx = shadow_used;
        for (k = 0; k < shadow_used; k++) begin
            if (shadow_addr[k] == addr) begin
                idx = k;
                break;
            end
        end
        t.outcome = OUT_KNOWN;
        if (idx == shadow_used) begin
            if (shadow_used >= SLOT_COUNT) begin
                t.report    = 1'b0;
                t.hit_total = '0;
                t.outcome   = OUT_FULL;
                return t;
            end
            shadow_addr[idx] = addr;
            shadow_hits[idx] = '0;
            shadow_used++;
            t.outcome = OUT_NEW;
        end
        // saturate at all ones
        if (shadow_hits[idx] != '1)
            shadow_hits[idx] = shadow_hits[idx] + HITS_W'(1);
        t.hit_total = shadow_hits[idx];
        t.report    = is_decade(t.hit_total);
        return t;
    endfunction

    task automatic flag_mismatch(input string what, input logic [HITS_W-1:0] got,
                                 input logic [HITS_W-1:0] want);
        $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offer one item and hold it until the block takes it
    task automatic send_event(input logic [ADDR_W-1:0] addr, input logic typed,
                              input tally_t typed_tally);
        tally_t predicted;
        start           <= 1'b1;
        i_event_address <= addr;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predicted = predict_tally(addr);
        expected_tallies.push_back(typed ? typed_tally : predicted);
        events_sent++;
    endtask

    // Random sender gap, geometric in length
    task automatic idle_gap(input int pct);
        int n;
        n = 0;
        while (n < MAX_GAP && $urandom_range(99) < pct)
            n++;
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Hold the sender off until every outstanding tally has come back
    task automatic drain_pause();
        start <= 1'b0;
        while (expected_tallies.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly known addresses, with near misses and random noise that get dropped
    function automatic logic [ADDR_W-1:0] pick_address(input logic [ADDR_W-1:0] hot);
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return hot;
        if (sel < 75)
            return shadow_addr[$urandom_range(shadow_used - 1)];
        if (sel < 88)
            return shadow_addr[$urandom_range(shadow_used - 1)] ^ (32'h1 << $urandom_range(31));
        return $urandom;
    endfunction

    // Stimulus
    initial begin
        logic [ADDR_W-1:0] hot_addr;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_N; r++) begin
            send_event(directed_rows[r].addr, directed_rows[r].typed, directed_rows[r].tally);
            idle_gap(25);
        end
        drain_pause();

        // one address gets hammered so its count passes 10 and 100
        hot_addr = shadow_addr[$urandom_range(SLOT_COUNT - 1)];
        for (int p = 0; p < PHASE_N; p++) begin
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_event(pick_address(hot_addr), 1'b0, '0);
                idle_gap(phase_idle_pct[p]);
            end
            drain_pause();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_tallies.size() != 0)
            flag_mismatch("tallies never delivered", '0, HITS_W'(expected_tallies.size()));

        $display("Covered %0d events (%0d directed) over %0d idle phases: %0d tallies checked,",
                 events_sent, DIRECTED_N, PHASE_N, tallies_checked);
        $display("%0d power-of-ten reports, %0d events dropped on a full table.",
                 reports_seen, drops_seen);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Result checker and activity tracking
    always @(posedge i_clk) begin
        tally_t want;
        if (i_rst_n) begin
            if (o_result_valid) begin
                if (expected_tallies.size() == 0) begin
                    flag_mismatch("result with nothing expected", o_hit_total, '0);
                end else begin
                    want = expected_tallies.pop_front();
                    tallies_checked++;
                    if (o_report !== want.report)
                        flag_mismatch("report", HITS_W'(o_report), HITS_W'(want.report));
                    if (o_hit_total !== want.hit_total)
                        flag_mismatch("hit_total", o_hit_total, want.hit_total);
                    if (o_outcome !== want.outcome)
                        flag_mismatch("outcome", HITS_W'(o_outcome), HITS_W'(want.outcome));
                    if (want.report)
                        reports_seen++;
                    if (want.outcome == OUT_FULL)
                        drops_seen++;
                end
            end
            if (o_result_valid || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // Watchdog on cycles with no item and no result accepted
    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("Watchdog: no activity for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/ear_pkg.sv
rtl/core/ear_slot_mem.sv
rtl/core/ear_pow10.sv
rtl/core/event_address_rate_limiter.sv
dv/event_address_rate_limiter_tb.sv
